[hw/rtl/bilinear_texture_sampler_wrap_defines.svh]
// Assertion macros shared by the texture sampler RTL.
`ifndef BILINEAR_TEXTURE_SAMPLER_WRAP_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_WRAP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bts: same-cycle property violated");

// Next-cycle implication, disabled during reset.
`define BTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bts: next-cycle property violated");

`endif

[hw/rtl/bts_pkg.sv]
// Shared constants and helpers of the bilinear texture sampler.
`default_nettype none

package bts_pkg;

   localparam int FRACTION_BITS       = 16;
   localparam int SIZE_W              = 9;
   localparam int CHAN_W              = 8;
   localparam int TEXEL_W             = 3 * CHAN_W;
   localparam int SAMPLE_W            = 16;
   localparam int MAX_ROWS_DEFAULT    = 256;
   localparam int MAX_COLUMNS_DEFAULT = 256;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

   localparam logic REG_HEIGHT = 1'b0;
   localparam logic REG_WIDTH  = 1'b1;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size_reg,
                                                     input int max_size);
      logic [SIZE_W-1:0] result;
      if (size_reg == '0) begin
         result = SIZE_W'(1);
      end else if (32'(size_reg) > max_size) begin
         result = SIZE_W'(max_size);
      end else begin
         result = size_reg;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/bts_texel_ram.sv]
// Single-port-write, single-port-read texel memory with registered read data.
`default_nettype none

module bts_texel_ram
   import bts_pkg::*;
#(
   parameter int ADDR_W = 16
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [TEXEL_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [TEXEL_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [TEXEL_W-1:0] texel_mem [DEPTH];
   logic [TEXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         texel_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= texel_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/bilinear_texture_sampler_wrap.sv]
// Bilinear texture sampler with wrap addressing: control, arithmetic and CSRs.
// The req channel carries one transaction per item: operation 0 stores one RGB texel at
// texel_row and texel_column, operation 1 samples at the Q0.16 pair coord_u_fraction and
// coord_v_fraction. Each sample produces one rsp transaction of Q8.8 red, green and blue;
// a texel write produces none. The texture height and width live in two CSRs at byte
// addresses 0 and 4 of the csr port; the user must write them only while the block is
// idle, as the block itself does not enforce it. A texel write is taken while the block
// is idle, and writes may follow back to back. A sample runs through scale, index, a
// fetch of the four neighbor texels, one per cycle over the RAM's single read port,
// a drain and a round step. rsp_valid rises and req_ready returns in the same cycle, as
// the round step completes, so a new sample is taken only once the last has left it.
// The finished result sits in an output register; the block accepts new transactions
// while it waits. If rsp_ready stays low, the next sample holds in its round cycle until
// the output register empties. Reset clears the control state and sets both size CSRs
// to 256; the texel memory is not cleared and must be written before it is sampled.
`default_nettype none
`include "bilinear_texture_sampler_wrap_defines.svh"

module bilinear_texture_sampler_wrap
   import bts_pkg::*;
#(
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT,
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_operation,
   input  wire logic [7:0]            req_texel_row,
   input  wire logic [7:0]            req_texel_column,
   input  wire logic [CHAN_W-1:0]     req_write_red,
   input  wire logic [CHAN_W-1:0]     req_write_green,
   input  wire logic [CHAN_W-1:0]     req_write_blue,
   input  wire logic [15:0]           req_coord_u_fraction,
   input  wire logic [15:0]           req_coord_v_fraction,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [SAMPLE_W-1:0]   rsp_sample_red,
   output logic      [SAMPLE_W-1:0]   rsp_sample_green,
   output logic      [SAMPLE_W-1:0]   rsp_sample_blue,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int RB      = $clog2(MAX_ROWS);
   localparam int CB      = $clog2(MAX_COLUMNS);
   localparam int ADDR_W  = RB + CB;
   localparam int FB      = FRACTION_BITS;
   localparam int PROD_W  = FB + SIZE_W;
   localparam int WGT_W   = FB + 1;
   localparam int WT_W    = 2 * WGT_W;
   localparam int ACC_W   = 2 * FB + CHAN_W;
   localparam int SHIFT   = 2 * FB - 8;

   localparam logic [WGT_W-1:0] WGT_ONE   = WGT_W'(1) << FB;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SHIFT - 1);
   localparam logic [1:0]       LAST_STEP = 2'd3;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCALE = 6'b000010,
      ST_INDEX = 6'b000100,
      ST_FETCH = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_ROUND = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  height_ff, height_in;
   logic [SIZE_W-1:0]  width_ff, width_in;
   logic [FB-1:0]      u_ff, u_in;
   logic [FB-1:0]      v_ff, v_in;
   logic [PROD_W-1:0]  pu_ff, pu_in;
   logic [PROD_W-1:0]  pv_ff, pv_in;
   logic [SIZE_W-1:0]  r0_ff, r0_in, r1_ff, r1_in;
   logic [SIZE_W-1:0]  c0_ff, c0_in, c1_ff, c1_in;
   logic [WGT_W-1:0]   wr0_ff, wr0_in, wr1_ff, wr1_in;
   logic [WGT_W-1:0]   wc0_ff, wc0_in, wc1_ff, wc1_in;
   logic [1:0]         step_ff, step_in;
   logic [WT_W-1:0]    wt_ff, wt_in;
   logic               take_ff, take_in;
   logic [ACC_W-1:0]   acc_red_ff, acc_red_in;
   logic [ACC_W-1:0]   acc_green_ff, acc_green_in;
   logic [ACC_W-1:0]   acc_blue_ff, acc_blue_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   logic [SIZE_W-1:0]  h_use, w_use;
   logic [SIZE_W:0]    r_next, c_next;
   logic [SIZE_W-1:0]  row_sel, col_sel;
   logic [WGT_W-1:0]   wr_sel, wc_sel;
   logic [ACC_W-1:0]   red_sum, green_sum, blue_sum;
   logic               req_fire, csr_write, out_free;

   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [TEXEL_W-1:0] ram_wr_data, ram_rd_data;

   bts_texel_ram #(
      .ADDR_W (ADDR_W)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_WIDTH) ? CSR_DATA_W'(width_ff)
                                                   : CSR_DATA_W'(height_ff);

   assign h_use = clamp_size(height_ff, MAX_ROWS);
   assign w_use = clamp_size(width_ff, MAX_COLUMNS);

   assign r_next = {1'b0, pu_ff[PROD_W-1:FB]} + (SIZE_W + 1)'(1);
   assign c_next = {1'b0, pv_ff[PROD_W-1:FB]} + (SIZE_W + 1)'(1);

   assign row_sel = step_ff[1] ? r1_ff : r0_ff;
   assign col_sel = step_ff[0] ? c1_ff : c0_ff;
   assign wr_sel  = step_ff[1] ? wr1_ff : wr0_ff;
   assign wc_sel  = step_ff[0] ? wc1_ff : wc0_ff;

   assign ram_wr_en   = req_fire && (req_operation == OP_WRITE) &&
                        (32'(req_texel_row) < MAX_ROWS) &&
                        (32'(req_texel_column) < MAX_COLUMNS);
   assign ram_wr_addr = {RB'(req_texel_row), CB'(req_texel_column)};
   assign ram_wr_data = {req_write_red, req_write_green, req_write_blue};
   assign ram_rd_en   = (state_ff == ST_FETCH);
   assign ram_rd_addr = {RB'(row_sel), CB'(col_sel)};

   assign red_sum   = acc_red_ff + ROUND_HALF;
   assign green_sum = acc_green_ff + ROUND_HALF;
   assign blue_sum  = acc_blue_ff + ROUND_HALF;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      pu_in        = pu_ff;
      pv_in        = pv_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      wr0_in       = wr0_ff;
      wr1_in       = wr1_ff;
      wc0_in       = wc0_ff;
      wc1_in       = wc1_ff;
      step_in      = step_ff;
      wt_in        = wt_ff;
      take_in      = 1'b0;
      acc_red_in   = acc_red_ff;
      acc_green_in = acc_green_ff;
      acc_blue_in  = acc_blue_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;

      if (csr_write) begin
         if (csr_paddr[2] == REG_HEIGHT) begin
            height_in = csr_pwdata[SIZE_W-1:0];
         end else begin
            width_in = csr_pwdata[SIZE_W-1:0];
         end
      end

      if (take_ff) begin
         acc_red_in   = acc_red_ff +
                        ACC_W'(ram_rd_data[3*CHAN_W-1:2*CHAN_W]) * ACC_W'(wt_ff);
         acc_green_in = acc_green_ff +
                        ACC_W'(ram_rd_data[2*CHAN_W-1:CHAN_W]) * ACC_W'(wt_ff);
         acc_blue_in  = acc_blue_ff +
                        ACC_W'(ram_rd_data[CHAN_W-1:0]) * ACC_W'(wt_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_operation == OP_SAMPLE)) begin
               u_in     = req_coord_u_fraction[FB-1:0];
               v_in     = req_coord_v_fraction[FB-1:0];
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            pu_in    = PROD_W'(u_ff) * PROD_W'(h_use);
            pv_in    = PROD_W'(v_ff) * PROD_W'(w_use);
            state_in = ST_INDEX;
         end
         ST_INDEX: begin
            r0_in        = pu_ff[PROD_W-1:FB];
            c0_in        = pv_ff[PROD_W-1:FB];
            r1_in        = (r_next >= {1'b0, h_use}) ? '0 : r_next[SIZE_W-1:0];
            c1_in        = (c_next >= {1'b0, w_use}) ? '0 : c_next[SIZE_W-1:0];
            wr1_in       = {1'b0, pu_ff[FB-1:0]};
            wc1_in       = {1'b0, pv_ff[FB-1:0]};
            wr0_in       = WGT_ONE - {1'b0, pu_ff[FB-1:0]};
            wc0_in       = WGT_ONE - {1'b0, pv_ff[FB-1:0]};
            acc_red_in   = '0;
            acc_green_in = '0;
            acc_blue_in  = '0;
            step_in      = '0;
            state_in     = ST_FETCH;
         end
         ST_FETCH: begin
            wt_in   = WT_W'(wr_sel) * WT_W'(wc_sel);
            take_in = 1'b1;
            step_in = step_ff + 2'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (out_free) begin
               red_in       = red_sum[SHIFT+SAMPLE_W-1:SHIFT];
               green_in     = green_sum[SHIFT+SAMPLE_W-1:SHIFT];
               blue_in      = blue_sum[SHIFT+SAMPLE_W-1:SHIFT];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         height_ff    <= SIZE_RESET;
         width_ff     <= SIZE_RESET;
         take_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         take_ff      <= take_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff         <= u_in;
      v_ff         <= v_in;
      pu_ff        <= pu_in;
      pv_ff        <= pv_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      c0_ff        <= c0_in;
      c1_ff        <= c1_in;
      wr0_ff       <= wr0_in;
      wr1_ff       <= wr1_in;
      wc0_ff       <= wc0_in;
      wc1_ff       <= wc1_in;
      wt_ff        <= wt_in;
      acc_red_ff   <= acc_red_in;
      acc_green_ff <= acc_green_in;
      acc_blue_ff  <= acc_blue_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_red   = red_ff;
   assign rsp_sample_green = green_ff;
   assign rsp_sample_blue  = blue_ff;

   `BTS_ASSERT_NEXT(a_sample_starts, clock, reset, req_fire && (req_operation == OP_SAMPLE), state_ff == ST_SCALE)
   `BTS_ASSERT_NEXT(a_fetch_ends, clock, reset, (state_ff == ST_FETCH) && (step_ff == LAST_STEP), state_ff == ST_DRAIN)
   `BTS_ASSERT_SAME(a_take_after_fetch, clock, reset, take_ff, $past(state_ff) == ST_FETCH)
   `BTS_ASSERT_SAME(a_rsp_from_round, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_ROUND)
   `BTS_ASSERT_SAME(a_write_only_idle, clock, reset, ram_wr_en, !ram_rd_en && !take_ff)

endmodule

`default_nettype wire

[sim/tb_bilinear_texture_sampler_wrap.sv]
// Testbench for the bilinear texture sampler: texel writes, filtered samples and size CSRs.
`timescale 1ns / 100ps

module tb_bilinear_texture_sampler_wrap
   import bts_pkg::*;
();

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_ITEMS = 1800;
   localparam longint unsigned ONE_Q16    = 64'd1 << FRACTION_BITS;
   localparam longint unsigned SAMPLE_MAX = 64'd255 << 8;
   localparam logic [CSR_ADDR_W-1:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};

   typedef struct {
      logic              operation;
      logic [7:0]        row;
      logic [7:0]        column;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [15:0]       coord_u;
      logic [15:0]       coord_v;
   } texture_request_type;

   typedef struct {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
   } filtered_rgb_type;

   typedef struct {
      int unsigned       row0;
      int unsigned       row1;
      int unsigned       col0;
      int unsigned       col1;
      longint unsigned   row_weight;
      longint unsigned   col_weight;
   } footprint_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_operation;
   logic [7:0]            req_texel_row;
   logic [7:0]            req_texel_column;
   logic [CHAN_W-1:0]     req_write_red;
   logic [CHAN_W-1:0]     req_write_green;
   logic [CHAN_W-1:0]     req_write_blue;
   logic [15:0]           req_coord_u_fraction;
   logic [15:0]           req_coord_v_fraction;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SAMPLE_W-1:0]   rsp_sample_red;
   logic [SAMPLE_W-1:0]   rsp_sample_green;
   logic [SAMPLE_W-1:0]   rsp_sample_blue;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [SIZE_W-1:0]  height_reg = SIZE_RESET;
   logic [SIZE_W-1:0]  width_reg  = SIZE_RESET;
   logic [TEXEL_W-1:0] texel_mem [0:MAX_ROWS_DEFAULT*MAX_COLUMNS_DEFAULT-1];
   bit                 texel_written [0:MAX_ROWS_DEFAULT*MAX_COLUMNS_DEFAULT-1];
   filtered_rgb_type   expected_rgb [$];
   int                 error_count = 0;
   int                 items_sent = 0;
   int                 burst_left = 0;
   bit                 gaps_on = 1'b1;
   longint             cycle_count = 0;
   logic [15:0]        ready_pattern;
   logic [3:0]         pattern_phase;
   int                 pattern_left;

   bilinear_texture_sampler_wrap dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_texel_row        (req_texel_row),
      .req_texel_column     (req_texel_column),
      .req_write_red        (req_write_red),
      .req_write_green      (req_write_green),
      .req_write_blue       (req_write_blue),
      .req_coord_u_fraction (req_coord_u_fraction),
      .req_coord_v_fraction (req_coord_v_fraction),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_sample_red       (rsp_sample_red),
      .rsp_sample_green     (rsp_sample_green),
      .rsp_sample_blue      (rsp_sample_blue),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int unsigned effective_size(input logic [SIZE_W-1:0] size_reg,
                                                  input int unsigned max_size);
      if (size_reg == '0) begin
         return 1;
      end
      if (32'(size_reg) > max_size) begin
         return max_size;
      end
      return 32'(size_reg);
   endfunction

   function automatic footprint_type locate(input logic [15:0] coord_u,
                                            input logic [15:0] coord_v);
      footprint_type fp;
      int unsigned rows;
      int unsigned cols;
      longint unsigned scaled_u;
      longint unsigned scaled_v;
      rows = effective_size(height_reg, MAX_ROWS_DEFAULT);
      cols = effective_size(width_reg, MAX_COLUMNS_DEFAULT);
      scaled_u = 64'(coord_u) * 64'(rows);
      scaled_v = 64'(coord_v) * 64'(cols);
      fp.row0 = 32'(scaled_u >> FRACTION_BITS);
      fp.col0 = 32'(scaled_v >> FRACTION_BITS);
      fp.row_weight = scaled_u & (ONE_Q16 - 1);
      fp.col_weight = scaled_v & (ONE_Q16 - 1);
      fp.row1 = (fp.row0 + 1 >= rows) ? 0 : fp.row0 + 1;
      fp.col1 = (fp.col0 + 1 >= cols) ? 0 : fp.col0 + 1;
      if (fp.row0 >= rows) begin
         fp.row0 = rows - 1;
      end
      if (fp.col0 >= cols) begin
         fp.col0 = cols - 1;
      end
      return fp;
   endfunction

   function automatic filtered_rgb_type blend(input logic [15:0] coord_u,
                                              input logic [15:0] coord_v);
      footprint_type fp;
      logic [TEXEL_W-1:0] texel [4];
      longint unsigned weight [4];
      longint unsigned acc;
      logic [SAMPLE_W-1:0] channel [3];
      filtered_rgb_type result;
      int ch;
      int k;
      fp = locate(coord_u, coord_v);
      texel[0] = texel_mem[fp.row0 * MAX_COLUMNS_DEFAULT + fp.col0];
      texel[1] = texel_mem[fp.row0 * MAX_COLUMNS_DEFAULT + fp.col1];
      texel[2] = texel_mem[fp.row1 * MAX_COLUMNS_DEFAULT + fp.col0];
      texel[3] = texel_mem[fp.row1 * MAX_COLUMNS_DEFAULT + fp.col1];
      weight[0] = (ONE_Q16 - fp.row_weight) * (ONE_Q16 - fp.col_weight);
      weight[1] = (ONE_Q16 - fp.row_weight) * fp.col_weight;
      weight[2] = fp.row_weight * (ONE_Q16 - fp.col_weight);
      weight[3] = fp.row_weight * fp.col_weight;
      for (ch = 0; ch < 3; ch++) begin
         acc = 0;
         for (k = 0; k < 4; k++) begin
            acc += 64'(texel[k][CHAN_W*(2-ch) +: CHAN_W]) * weight[k];
         end
         acc = (acc + (64'd1 << (2*FRACTION_BITS - 9))) >> (2*FRACTION_BITS - 8);
         if (acc > SAMPLE_MAX) begin
            acc = SAMPLE_MAX;
         end
         channel[ch] = acc[SAMPLE_W-1:0];
      end
      result.red   = channel[0];
      result.green = channel[1];
      result.blue  = channel[2];
      return result;
   endfunction

   function automatic logic [15:0] random_coord(input int unsigned size);
      int unsigned k;
      longint unsigned boundary;
      case ($urandom_range(0, 7))
         0: begin
            return 16'h0000;
         end
         1: begin
            return 16'hFFFF;
         end
         2, 3: begin
            k = $urandom_range(0, size - 1);
            boundary = (64'(k) * ONE_Q16 + size - 1) / size;
            if ($urandom_range(0, 1) == 1 && boundary > 0) begin
               boundary--;
            end
            return boundary[15:0];
         end
         default: begin
            return 16'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return SIZE_W'(1);
         2: return SIZE_W'(2);
         3: return SIZE_W'(256);
         4: return SIZE_W'($urandom_range(257, 511));
         default: return SIZE_W'($urandom_range(1, 256));
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [SAMPLE_W-1:0] expected,
                                       input logic [SAMPLE_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      filtered_rgb_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rgb.size() == 0) begin
            $error("rsp transaction with no sample outstanding");
            error_count++;
         end else begin
            want = expected_rgb.pop_front();
            check_field("sample_red", want.red, rsp_sample_red);
            check_field("sample_green", want.green, rsp_sample_green);
            check_field("sample_blue", want.blue, rsp_sample_blue);
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      ready_pattern = '1;
      pattern_phase = '0;
      pattern_left = 0;
      forever begin
         @(negedge clock);
         if (pattern_left == 0) begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            pattern_left = $urandom_range(50, 400);
         end
         pattern_left--;
         rsp_ready = ready_pattern[pattern_phase];
         pattern_phase = pattern_phase + 1'b1;
      end
   end

   task automatic send_item(input texture_request_type item);
      @(negedge clock);
      if (gaps_on && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_operation        = item.operation;
      req_texel_row        = item.row;
      req_texel_column     = item.column;
      req_write_red        = item.red;
      req_write_green      = item.green;
      req_write_blue       = item.blue;
      req_coord_u_fraction = item.coord_u;
      req_coord_v_fraction = item.coord_v;
      req_valid            = 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (item.operation == OP_WRITE) begin
         texel_mem[{item.row, item.column}] = {item.red, item.green, item.blue};
         texel_written[{item.row, item.column}] = 1'b1;
      end else begin
         expected_rgb.insert(expected_rgb.size(), blend(item.coord_u, item.coord_v));
      end
   endtask

   task automatic write_texel(input logic [7:0] row, input logic [7:0] column,
                              input logic [TEXEL_W-1:0] color);
      texture_request_type item;
      item.operation = OP_WRITE;
      item.row = row;
      item.column = column;
      {item.red, item.green, item.blue} = color;
      item.coord_u = 16'($urandom);
      item.coord_v = 16'($urandom);
      send_item(item);
   endtask

   task automatic cover_texel(input int unsigned row, input int unsigned column);
      if (!texel_written[row * MAX_COLUMNS_DEFAULT + column]) begin
         write_texel(8'(row), 8'(column), TEXEL_W'($urandom));
      end
   endtask

   task automatic sample_at(input logic [15:0] coord_u, input logic [15:0] coord_v);
      footprint_type fp;
      texture_request_type item;
      fp = locate(coord_u, coord_v);
      cover_texel(fp.row0, fp.col0);
      cover_texel(fp.row0, fp.col1);
      cover_texel(fp.row1, fp.col0);
      cover_texel(fp.row1, fp.col1);
      item.operation = OP_SAMPLE;
      item.row = 8'($urandom);
      item.column = 8'($urandom);
      {item.red, item.green, item.blue} = TEXEL_W'($urandom);
      item.coord_u = coord_u;
      item.coord_v = coord_v;
      send_item(item);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [SIZE_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data[SIZE_W-1:0] = value;
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic csr_check(input logic [CSR_ADDR_W-1:0] addr, input logic [SIZE_W-1:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b0;
      csr_penable = 1'b0;
      csr_paddr = addr;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[SIZE_W-1:0] !== value) begin
         $error("csr_prdata at %0d: expected %0d, actual %0d", addr, value,
                csr_prdata[SIZE_W-1:0]);
         error_count++;
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_sizes(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
      wait_idle();
      csr_write(HEIGHT_ADDR, rows);
      height_reg = rows;
      csr_write(WIDTH_ADDR, cols);
      width_reg = cols;
      csr_check(HEIGHT_ADDR, rows);
      csr_check(WIDTH_ADDR, cols);
   endtask

   task automatic test_reset_values();
      csr_check(HEIGHT_ADDR, SIZE_RESET);
      csr_check(WIDTH_ADDR, SIZE_RESET);
   endtask

   task automatic test_corner_texels();
      write_texel(8'd0, 8'd0, 24'hFFFFFF);
      write_texel(8'd0, 8'd1, 24'h000000);
      write_texel(8'd1, 8'd0, 24'hAA55AA);
      write_texel(8'd1, 8'd1, 24'h55AA55);
      write_texel(8'd255, 8'd255, 24'hFF00FF);
      write_texel(8'd255, 8'd0, 24'h00FF00);
      write_texel(8'd0, 8'd255, 24'h123456);
      sample_at(16'h0000, 16'h0000);
      sample_at(16'h0080, 16'h0080);
      sample_at(16'hFFFF, 16'hFFFF);
      sample_at(16'hFFFF, 16'h0000);
   endtask

   task automatic test_size_limits();
      set_sizes(SIZE_W'(1), SIZE_W'(1));
      sample_at(16'hFFFF, 16'h8000);
      set_sizes('0, '0);
      sample_at(16'h8000, 16'hFFFF);
      set_sizes('1, SIZE_W'(300));
      sample_at(16'hFFFF, 16'hFFFF);
      sample_at(16'h8000, 16'h7FFF);
      set_sizes(SIZE_W'(1), SIZE_W'(256));
      sample_at(16'h4000, 16'hFFFF);
      set_sizes(SIZE_W'(256), SIZE_W'(2));
      sample_at(16'hFFFF, 16'hC000);
      sample_at(16'h0001, 16'h7FFF);
   endtask

   task automatic test_random_traffic();
      int target;
      int phase_end;
      int unsigned rows;
      int unsigned cols;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         set_sizes(pick_size(), pick_size());
         gaps_on = ($urandom_range(0, 3) != 0);
         rows = effective_size(height_reg, MAX_ROWS_DEFAULT);
         cols = effective_size(width_reg, MAX_COLUMNS_DEFAULT);
         phase_end = items_sent + $urandom_range(100, 300);
         while (items_sent < phase_end && items_sent < target) begin
            if ($urandom_range(0, 9) < 4) begin
               if ($urandom_range(0, 2) == 0) begin
                  write_texel(8'($urandom), 8'($urandom), TEXEL_W'($urandom));
               end else begin
                  write_texel(8'($urandom_range(0, rows - 1)), 8'($urandom_range(0, cols - 1)),
                              TEXEL_W'($urandom));
               end
            end else begin
               sample_at(random_coord(rows), random_coord(cols));
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_WRITE;
      req_texel_row = '0;
      req_texel_column = '0;
      req_write_red = '0;
      req_write_green = '0;
      req_write_blue = '0;
      req_coord_u_fraction = '0;
      req_coord_v_fraction = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_corner_texels();
      test_size_limits();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bts_pkg.sv
hw/rtl/bts_texel_ram.sv
hw/rtl/bilinear_texture_sampler_wrap.sv
sim/tb_bilinear_texture_sampler_wrap.sv
